/* rtl/core/matrix_determinant_cofactor_assert.svh */
// Assertion macros for the determinant block.
`ifndef MATRIX_DETERMINANT_COFACTOR_ASSERT_SVH
`define MATRIX_DETERMINANT_COFACTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mdc_pkg.sv */
package mdc_pkg;

  localparam int MATRIX_SIZE = 4;
  localparam int ENTRY_TOTAL = MATRIX_SIZE * MATRIX_SIZE;
  localparam int ENTRY_W     = 16;
  localparam int ENTRY_AW    = $clog2(ENTRY_TOTAL);
  localparam int CNT_W       = $clog2(ENTRY_TOTAL + 1);
  localparam int COL_W       = $clog2(MATRIX_SIZE);
  localparam int PC_W        = $clog2(MATRIX_SIZE + 1);
  localparam int MINOR_DEPTH = 2 ** MATRIX_SIZE;

  // |det| < N! * 2^(15N) and N! < 2^16 for N <= 8, rounded up to 32-bit chunks
  localparam int ACC_W       = 32 * ((16 * MATRIX_SIZE + 16 + 31) / 32);
  localparam int CHUNKS      = ACC_W / 32;
  localparam int CHUNK_IDX_W = $clog2(CHUNKS);
  localparam int DET_W       = 64;

  typedef struct packed {
    logic                   clear;
    logic                   step;
    logic [CHUNK_IDX_W-1:0] chunk;
    logic                   neg;
    logic                   entry_ok;
    logic                   unit_minor;
  } mac_ctrl_t;

endpackage

/* rtl/core/mdc_ram.sv */
module mdc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/mdc_mac.sv */
module mdc_mac import mdc_pkg::*; (
  input  logic               clk,
  input  mac_ctrl_t          ctrl,
  input  logic [ENTRY_W-1:0] entry_rd,
  input  logic [ACC_W-1:0]   minor_rd,
  output logic [ACC_W-1:0]   acc
);

  logic               [ACC_W-1:0] acc_r;
  logic               [ACC_W-1:0] acc_nxt;
  logic signed        [16:0]      ev;
  logic signed        [16:0]      mult;
  logic               [31:0]      ch;
  logic signed        [32:0]      op;
  logic signed        [49:0]      prod;
  logic               [ACC_W-1:0] ext;
  logic               [ACC_W-1:0] shifted;

  always_comb begin
    ev   = ctrl.entry_ok ? {entry_rd[ENTRY_W-1], entry_rd} : '0;
    mult = ctrl.neg ? -ev : ev;
    if (ctrl.unit_minor) begin
      ch = (ctrl.chunk == '0) ? 32'd1 : 32'd0;
    end else begin
      ch = minor_rd[ctrl.chunk * 32 +: 32];
    end
    // lower chunks are unsigned digits, only the top one carries the sign
    op      = {(ctrl.chunk == CHUNK_IDX_W'(CHUNKS - 1)) & ch[31], ch};
    prod    = op * mult;
    ext     = {{(ACC_W - 50){prod[49]}}, prod};
    shifted = ext << {ctrl.chunk, 5'b0};
    acc_nxt = acc_r + shifted;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (ctrl.step) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

/* rtl/core/matrix_determinant_cofactor.sv */
// Determinant of an N x N signed Q8.8 matrix (N = MATRIX_SIZE in mdc_pkg).
// Input channel: one entry per transfer, row-major, in_last_entry on the
// final one. Entries load at one per cycle. Entries beyond N*N are dropped;
// a matrix closed early reads its missing entries as zero.
// After the last entry the block stalls its input and expands by cofactors:
// every nonempty column subset's minor is built once, in increasing order, and
// kept in a minor RAM. One 33x17 multiplier walks each minor 32 bits a cycle
// and feeds a single wide accumulator.
// Result channel: out_det_value has 8*N fraction bits, saturated to 64 bits,
// out_overflow set when saturated. It sits in an output register; loading
// of the next matrix proceeds while it waits. If the receiver still stalls
// when the next determinant is ready, that determinant waits in the block.
// Reset (rst_n low, synchronous) empties the matrix and drops any result.
module matrix_determinant_cofactor import mdc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ENTRY_W-1:0] in_entry_value,
  input  logic                    in_last_entry,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DET_W-1:0] out_det_value,
  output logic                    out_overflow
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_COL,
    S_MUL,
    S_WRITE,
    S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [MATRIX_SIZE-1:0]   mask_r, mask_nxt;
  logic [COL_W-1:0]         col_r, col_nxt;
  logic                     parity_r, parity_nxt;
  logic [CHUNK_IDX_W-1:0]   chunk_r, chunk_nxt;
  logic                     neg_r, neg_nxt;
  logic                     ok_r, ok_nxt;
  logic                     unit_r, unit_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [DET_W-1:0]         out_det_r, out_det_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  logic                     in_xfer;
  logic                     start;
  logic [PC_W-1:0]          pc;
  logic [COL_W-1:0]         row;
  logic [CNT_W-1:0]         idx;
  logic [MATRIX_SIZE-1:0]   sub_mask;
  logic                     col_last;
  logic                     mask_full;
  logic                     fits;
  mac_ctrl_t                mac_ctrl;
  logic [ENTRY_W-1:0]       entry_rd;
  logic [ACC_W-1:0]         minor_rd;
  logic [ACC_W-1:0]         acc;

  assign in_stall = (state_r != S_LOAD);
  assign in_xfer  = in_valid && !in_stall;
  assign start    = in_xfer && in_last_entry;

  always_comb begin
    pc = '0;
    for (int i = 0; i < MATRIX_SIZE; i++) begin
      pc = pc + PC_W'(mask_r[i]);
    end
  end

  // a subset of k columns belongs to the minor over the bottom k rows
  assign row       = COL_W'(PC_W'(MATRIX_SIZE) - pc);
  assign idx       = CNT_W'(row) * CNT_W'(MATRIX_SIZE) + CNT_W'(col_r);
  assign sub_mask  = mask_r & ~(MATRIX_SIZE'(1) << col_r);
  assign col_last  = (col_r == COL_W'(MATRIX_SIZE - 1));
  assign mask_full = (mask_r == '1);
  assign fits      = (acc[ACC_W-1:DET_W-1] == '0) || (acc[ACC_W-1:DET_W-1] == '1);

  always_comb begin
    // the full-matrix sum stays in the accumulator until the next matrix's last entry clears it
    mac_ctrl.clear      = start || ((state_r == S_WRITE) && !mask_full);
    mac_ctrl.step       = (state_r == S_MUL);
    mac_ctrl.chunk      = chunk_r;
    mac_ctrl.neg        = neg_r;
    mac_ctrl.entry_ok   = ok_r;
    mac_ctrl.unit_minor = unit_r;
  end

  mdc_ram #(
    .DEPTH (ENTRY_TOTAL),
    .WIDTH (ENTRY_W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (in_xfer && (count_r < CNT_W'(ENTRY_TOTAL))),
    .waddr (count_r[ENTRY_AW-1:0]),
    .wdata (in_entry_value),
    .re    (state_r == S_COL),
    .raddr (idx[ENTRY_AW-1:0]),
    .rdata (entry_rd)
  );

  mdc_ram #(
    .DEPTH (MINOR_DEPTH),
    .WIDTH (ACC_W)
  ) u_minor_ram (
    .clk   (clk),
    .we    (state_r == S_WRITE),
    .waddr (mask_r),
    .wdata (acc),
    .re    (state_r == S_COL),
    .raddr (sub_mask),
    .rdata (minor_rd)
  );

  mdc_mac u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .entry_rd (entry_rd),
    .minor_rd (minor_rd),
    .acc      (acc)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    mask_nxt      = mask_r;
    col_nxt       = col_r;
    parity_nxt    = parity_r;
    chunk_nxt     = chunk_r;
    neg_nxt       = neg_r;
    ok_nxt        = ok_r;
    unit_nxt      = unit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_det_nxt   = out_det_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (count_r < CNT_W'(ENTRY_TOTAL)) begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_last_entry) begin
            mask_nxt   = MATRIX_SIZE'(1);
            col_nxt    = '0;
            parity_nxt = 1'b0;
            state_nxt  = S_COL;
          end
        end
      end
      S_COL: begin
        if (mask_r[col_r]) begin
          ok_nxt     = (idx < count_r);
          neg_nxt    = parity_r;
          unit_nxt   = (sub_mask == '0);
          parity_nxt = !parity_r;
          chunk_nxt  = '0;
          state_nxt  = S_MUL;
        end else if (col_last) begin
          state_nxt = S_WRITE;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      S_MUL: begin
        chunk_nxt = chunk_r + CHUNK_IDX_W'(1);
        if (chunk_r == CHUNK_IDX_W'(CHUNKS - 1)) begin
          if (col_last) begin
            state_nxt = S_WRITE;
          end else begin
            col_nxt   = col_r + COL_W'(1);
            state_nxt = S_COL;
          end
        end
      end
      S_WRITE: begin
        if (mask_full) begin
          state_nxt = S_DONE;
        end else begin
          mask_nxt   = mask_r + MATRIX_SIZE'(1);
          col_nxt    = '0;
          parity_nxt = 1'b0;
          state_nxt  = S_COL;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ovf_nxt   = !fits;
          if (fits) begin
            out_det_nxt = acc[DET_W-1:0];
          end else if (acc[ACC_W-1]) begin
            out_det_nxt = {1'b1, {(DET_W - 1){1'b0}}};
          end else begin
            out_det_nxt = {1'b0, {(DET_W - 1){1'b1}}};
          end
          count_nxt = '0;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      mask_r      <= '0;
      col_r       <= '0;
      parity_r    <= 1'b0;
      chunk_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mask_r      <= mask_nxt;
      col_r       <= col_nxt;
      parity_r    <= parity_nxt;
      chunk_r     <= chunk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r     <= neg_nxt;
    ok_r      <= ok_nxt;
    unit_r    <= unit_nxt;
    out_det_r <= out_det_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_det_value = out_det_r;
  assign out_overflow  = out_ovf_r;

`include "matrix_determinant_cofactor_assert.svh"

  `MDC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(ENTRY_TOTAL),
                  "entry count ran past the matrix size")
  `MDC_ASSERT_NOW(a_mul_on_set_col, state_r == S_MUL, mask_r[col_r],
                  "multiply on a column outside the subset")
  `MDC_ASSERT_NEXT(a_full_mask_done, (state_r == S_WRITE) && mask_full,
                   state_r == S_DONE, "full subset written without finishing")
  `MDC_ASSERT_NOW(a_result_from_done, $rose(out_valid_r), $past(state_r) == S_DONE,
                  "result appeared outside the finish step")

endmodule
